// File: rtl/core/egbr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egbr_pkg
// Shared types, codes and tables of the Exp-Golomb bit reader.
// ----------------------------------------------------------------------------
package egbr_pkg;

    localparam int WINDOW_BITS    = 32;
    localparam int REFILL_BYTES   = 4;
    localparam int LANE_W         = $clog2(REFILL_BYTES);
    localparam int MAX_LEAD_ZEROS = 15;
    localparam logic [WINDOW_BITS-1:0] ERR_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_LOAD       = 3'd0,
        OP_READ_BITS  = 3'd1,
        OP_READ_BIT   = 3'd2,
        OP_UE         = 3'd3,
        OP_SE         = 3'd4,
        OP_NEW_STREAM = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_END  = 2'd1,
        ST_FULL = 2'd2,
        ST_LONG = 2'd3
    } status_t;

    // Leading zeros of one nibble.
    localparam logic [2:0] NIBBLE_LZ [16] = '{
        3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };

    // Leading zeros of a nonzero 16-bit word, one nibble at a time.
    function automatic logic [3:0] lead_zeros16(input logic [15:0] w);
        logic [4:0] n;
        logic       done;
        logic [3:0] nib;
        n    = '0;
        done = 1'b0;
        for (int i = 3; i >= 0; i--)
        begin
            nib = w[i*4 +: 4];
            if (!done)
            begin
                n = n + 5'(NIBBLE_LZ[nib]);
                if (nib != 4'd0)
                begin
                    done = 1'b1;
                end
            end
        end
        return n[3:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/exp_golomb_bit_reader.sv
`default_nettype none
// ----------------------------------------------------------------------------
// exp_golomb_bit_reader
// Byte store plus 32-bit MSB-first bit window serving fixed-length, one-bit,
// ue and se reads, one request per transaction.
// ----------------------------------------------------------------------------
// The reader takes one request per clock and answers each with exactly one
// result transaction: an accepted request is held in the input register while
// the decode logic works out the result, and the result register captures it
// when it may advance (empty or being read). Requests
// follow each other back to back; throughput drops only while the result
// register is stalled. The byte store is split into four interleaved banks
// so that the four bytes at the read pointer are always prefetched: each
// bank is addressed with the read pointer the current request leaves behind,
// and a byte written in the same cycle is forwarded around the bank. The
// store has no reset; bytes past the write pointer are masked, so no clearing
// pass is needed and the block is ready right after reset. Status 1 flags
// running past the loaded data, 3 a code longer than 32 bits (both return
// all ones), 2 a load into a full store (the byte is dropped). Opcode 5
// restarts the stream; opcodes 6 and 7 do nothing and return zero.
// ----------------------------------------------------------------------------
module exp_golomb_bit_reader
    import egbr_pkg::*;
#(
    parameter int STORE_BYTES = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         opcode,
    input  wire logic [7:0]         data_byte,
    input  wire logic [5:0]         bit_count,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic        [31:0]      unsigned_value,
    output logic signed [31:0]      signed_value,
    output logic        [1:0]       status
);

    localparam int PTR_W      = $clog2(STORE_BYTES + 1);
    localparam int BANK_DEPTH = (STORE_BYTES + REFILL_BYTES - 1) / REFILL_BYTES;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // Input register
    logic       s1_valid_reg;
    logic [2:0] s1_op_reg;
    logic [7:0] s1_byte_reg;
    logic [5:0] s1_cnt_reg;

    // Reader state
    logic [WINDOW_BITS-1:0] window_reg, window_next;
    logic [5:0]             vbits_reg, vbits_next;
    logic [PTR_W-1:0]       rp_reg, rp_next;
    logic [PTR_W-1:0]       wp_reg, wp_next;

    // Result register
    logic                          out_valid_reg;
    logic [WINDOW_BITS-1:0]        uval_reg, uval_next;
    logic signed [WINDOW_BITS-1:0] sval_reg, sval_next;
    status_t                       status_reg, status_next;

    // Handshake
    logic advance;
    logic fire;
    logic in_fire;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    opcode_t op;
    assign op = opcode_t'(s1_op_reg);

    // ------------------------------------------------------------------
    // Byte store banks with same-cycle write forwarding
    // ------------------------------------------------------------------
    logic                load_we;
    logic [BANK_AW-1:0]  bank_waddr;
    logic [BANK_AW-1:0]  bank_raddr   [REFILL_BYTES];
    logic                bank_we      [REFILL_BYTES];
    logic [7:0]          bank_q       [REFILL_BYTES];
    logic [7:0]          bank_byte    [REFILL_BYTES];
    logic                fwd_valid_reg[REFILL_BYTES];
    logic                fwd_valid_next[REFILL_BYTES];
    logic [7:0]          fwd_data_reg [REFILL_BYTES];

    assign bank_waddr = BANK_AW'(wp_reg >> LANE_W);

    for (genvar b = 0; b < REFILL_BYTES; b++)
    begin : g_bank
        logic [LANE_W-1:0] lane_off;
        logic [PTR_W-1:0]  lane_addr;

        // Bank b holds the byte at offset (b - rp) mod 4 from the read pointer
        assign lane_off      = LANE_W'(b) - rp_next[LANE_W-1:0];
        assign lane_addr     = rp_next + PTR_W'(lane_off);
        assign bank_raddr[b] = BANK_AW'(lane_addr >> LANE_W);
        assign bank_we[b]    = load_we && (wp_reg[LANE_W-1:0] == LANE_W'(b));

        // A write hitting the address being prefetched is forwarded next cycle
        assign fwd_valid_next[b] = bank_we[b] && (bank_waddr == bank_raddr[b]);
        assign bank_byte[b]      = fwd_valid_reg[b] ? fwd_data_reg[b] : bank_q[b];

        egbr_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (bank_waddr),
            .wdata (s1_byte_reg),
            .raddr (bank_raddr[b]),
            .rdata (bank_q[b])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fwd_valid_reg[b] <= 1'b0;
            end
            else
            begin
                fwd_valid_reg[b] <= fwd_valid_next[b];
            end
        end

        always_ff @(posedge clk)
        begin
            fwd_data_reg[b] <= s1_byte_reg;
        end
    end

    // ------------------------------------------------------------------
    // Refill word: the next (up to) four stored bytes, MSB first
    // ------------------------------------------------------------------
    logic [PTR_W-1:0]       avail;
    logic [2:0]             nb;
    logic [31:0]            bank_word;
    logic [63:0]            bank_dbl;
    logic [WINDOW_BITS-1:0] refill_word;

    assign avail     = wp_reg - rp_reg;
    assign nb        = (avail >= PTR_W'(REFILL_BYTES)) ? 3'(REFILL_BYTES) : avail[2:0];
    assign bank_word = {bank_byte[0], bank_byte[1], bank_byte[2], bank_byte[3]};
    // Rotate so the byte at the read pointer lands on top
    assign bank_dbl  = {bank_word, bank_word} << {rp_reg[LANE_W-1:0], 3'b000};
    // Drop bytes past the write pointer
    assign refill_word = bank_dbl[63:32] & ~(32'hFFFF_FFFF >> {nb, 3'b000});

    // ------------------------------------------------------------------
    // Bit extraction
    // ------------------------------------------------------------------
    logic [63:0]            c_ref;
    logic [63:0]            c_take;
    logic [63:0]            c_shift;
    logic [15:0]            lead16;
    logic [3:0]             lz;
    logic [5:0]             take_n;
    logic                   need_refill;
    logic [6:0]             seen_bits;
    logic                   short_data;
    logic [WINDOW_BITS-1:0] take_val;
    logic [6:0]             take_vbits;
    logic [PTR_W-1:0]       take_rp;
    logic [PTR_W-1:0]       ue_drop_rp;
    logic [WINDOW_BITS-1:0] code;
    logic [WINDOW_BITS-1:0] se_pos;
    logic [WINDOW_BITS-1:0] se_neg;

    // Window bits followed by the refill bytes; window bits below vbits are zero
    assign c_ref  = {window_reg, 32'b0} | ({refill_word, 32'b0} >> vbits_reg);
    assign lead16 = c_ref[63:48];
    assign lz     = lead_zeros16(lead16);

    always_comb
    begin
        case (op)
            OP_READ_BITS: take_n = (s1_cnt_reg > 6'd32) ? 6'd32 : s1_cnt_reg;
            OP_UE,
            OP_SE:        take_n = {1'b0, lz, 1'b1};
            default:      take_n = 6'd1;
        endcase
    end

    assign need_refill = vbits_reg < take_n;
    assign seen_bits   = {1'b0, vbits_reg} + {1'b0, nb, 3'b000};
    assign short_data  = need_refill && (seen_bits < {1'b0, take_n});
    assign c_take      = need_refill ? c_ref : {window_reg, 32'b0};
    assign take_val    = c_take[63:32] >> (6'd32 - take_n);
    assign c_shift     = c_take << take_n;
    assign take_vbits  = (need_refill ? seen_bits : {1'b0, vbits_reg}) - {1'b0, take_n};
    assign take_rp     = rp_reg + (need_refill ? PTR_W'(nb) : '0);
    assign ue_drop_rp  = rp_reg + ((window_reg == '0) ? PTR_W'(nb) : '0);

    assign code   = take_val - 32'd1;
    assign se_pos = (code + 32'd1) >> 1;
    assign se_neg = 32'd0 - (code >> 1);

    // ------------------------------------------------------------------
    // Request decode and next state
    // ------------------------------------------------------------------
    always_comb
    begin
        window_next = window_reg;
        vbits_next  = vbits_reg;
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        uval_next   = '0;
        sval_next   = '0;
        status_next = ST_OK;
        load_we     = 1'b0;
        if (fire)
        begin
            case (op)
                OP_LOAD:
                begin
                    if (wp_reg < PTR_W'(STORE_BYTES))
                    begin
                        load_we = 1'b1;
                        wp_next = wp_reg + PTR_W'(1);
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                OP_READ_BITS,
                OP_READ_BIT:
                begin
                    // A zero bit count reads nothing
                    if (op == OP_READ_BIT || s1_cnt_reg != 6'd0)
                    begin
                        rp_next = take_rp;
                        if (short_data)
                        begin
                            window_next = '0;
                            vbits_next  = '0;
                            uval_next   = ERR_VALUE;
                            status_next = ST_END;
                        end
                        else
                        begin
                            window_next = c_shift[63:32];
                            vbits_next  = take_vbits[5:0];
                            uval_next   = take_val;
                        end
                    end
                end
                OP_UE,
                OP_SE:
                begin
                    if (c_ref == '0)
                    begin
                        // Nothing but zeros in the window and the refill bytes
                        window_next = '0;
                        vbits_next  = '0;
                        rp_next     = ue_drop_rp;
                        uval_next   = ERR_VALUE;
                        status_next = (seen_bits > 7'(MAX_LEAD_ZEROS)) ? ST_LONG : ST_END;
                    end
                    else if (lead16 == '0)
                    begin
                        window_next = '0;
                        vbits_next  = '0;
                        rp_next     = ue_drop_rp;
                        uval_next   = ERR_VALUE;
                        status_next = ST_LONG;
                    end
                    else if (short_data)
                    begin
                        window_next = '0;
                        vbits_next  = '0;
                        rp_next     = take_rp;
                        uval_next   = ERR_VALUE;
                        status_next = ST_END;
                    end
                    else
                    begin
                        window_next = c_shift[63:32];
                        vbits_next  = take_vbits[5:0];
                        rp_next     = take_rp;
                        uval_next   = code;
                        if (op == OP_SE)
                        begin
                            // Odd codes map positive, even codes to zero or negative
                            sval_next = signed'(code[0] ? se_pos : se_neg);
                        end
                    end
                end
                OP_NEW_STREAM:
                begin
                    window_next = '0;
                    vbits_next  = '0;
                    rp_next     = '0;
                    wp_next     = '0;
                end
                default:
                begin
                    // Unused opcode: no operation
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= '0;
            vbits_reg     <= '0;
            rp_reg        <= '0;
            wp_reg        <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            window_reg <= window_next;
            vbits_reg  <= vbits_next;
            rp_reg     <= rp_next;
            wp_reg     <= wp_next;
        end
    end

    // Payload registers: hold until the next transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg   <= opcode;
            s1_byte_reg <= data_byte;
            s1_cnt_reg  <= bit_count;
        end
        if (fire)
        begin
            uval_reg   <= uval_next;
            sval_reg   <= sval_next;
            status_reg <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign unsigned_value = uval_reg;
    assign signed_value   = sval_reg;
    assign status         = status_reg;

endmodule
`default_nettype wire

// File: rtl/core/egbr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egbr_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module egbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/core/egbr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egbr_checker
// Port-level checks of the Exp-Golomb bit reader, bound to the top level.
// ----------------------------------------------------------------------------
module egbr_checker
    import egbr_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic        [31:0] unsigned_value,
    input wire logic signed [31:0] signed_value,
    input wire logic        [1:0]  status
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(unsigned_value)
            && $stable(signed_value) && $stable(status))
        else $error("result changed while stalled");

    // Read errors return all ones and no signed value
    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_END || status == ST_LONG)
            |-> unsigned_value == ERR_VALUE && signed_value == 0)
        else $error("error result carries a value");

    // A dropped load returns zero
    a_full_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> unsigned_value == 0 && signed_value == 0)
        else $error("full-store result carries a value");

    // A signed value only comes from a good se read
    a_signed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && signed_value != 0 |-> status == ST_OK)
        else $error("signed value with error status");

    // An empty result register never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

bind exp_golomb_bit_reader egbr_checker u_egbr_checker (.*);
`default_nettype wire

// File: verif/tb_exp_golomb_bit_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exp_golomb_bit_reader
// Self-checking bench for the Exp-Golomb bit reader: a queue-fed driver
// offers requests, a request-level predictor tracks the window and byte store,
// and a monitor checks every result transaction in order.
// ----------------------------------------------------------------------------
module tb_exp_golomb_bit_reader
    import egbr_pkg::*;
;

    localparam int STORE_BYTES    = 1024;
    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 1925;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 500000;

    // Opcodes the block decodes as no-ops.
    localparam logic [2:0] OP_NOP6 = 3'd6;
    localparam logic [2:0] OP_NOP7 = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] byt;
        logic [5:0] cnt;
    } request_t;

    typedef struct packed {
        logic [31:0] uval;
        logic [31:0] sval;
        status_t     st;
    } reply_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [2:0]         opcode    = OP_LOAD;
    logic [7:0]         data_byte = '0;
    logic [5:0]         bit_count = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [31:0]        unsigned_value;
    logic signed [31:0] signed_value;
    logic [1:0]         status;

    initial
    begin
        forever #2 clk = ~clk;
    end

    exp_golomb_bit_reader #(
        .STORE_BYTES (STORE_BYTES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .data_byte      (data_byte),
        .bit_count      (bit_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .unsigned_value (unsigned_value),
        .signed_value   (signed_value),
        .status         (status)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    request_t    pending_reqs [$];   // requests not yet offered
    reply_t      replies_due  [$];   // predicted results, oldest first
    request_t    live_req;           // request currently on the input port
    int unsigned requests_sent = 0;
    int unsigned results_seen  = 0;
    int unsigned fail_count    = 0;
    int unsigned total_reqs    = 0;
    int unsigned cycle_count   = 0;
    int unsigned op_hits     [8];
    int unsigned status_hits [4];

    // Shadow of the reader: window, bit count, store and both pointers.
    logic [7:0]  shadow_store [STORE_BYTES];
    logic [31:0] shadow_window = '0;
    int unsigned shadow_valid  = 0;
    int unsigned shadow_rd     = 0;
    int unsigned shadow_wr     = 0;

    // Stimulus generator bookkeeping.
    bit          code_bits [$];      // bitstream under construction, MSB first
    int unsigned gen_wr      = 0;    // write pointer as the generator sees it
    bit          fill_done   = 1'b0;

    // ------------------------------------------------------------------------
    // Shadow reader
    // ------------------------------------------------------------------------
    function automatic int unsigned leading_zeros(logic [31:0] w);
        int unsigned n;
        n = 0;
        for (int i = 31; i >= 0; i--)
        begin
            if (w[i])
            begin
                return n;
            end
            n++;
        end
        return n;
    endfunction

    // Look at the next refill bytes without consuming them.
    function automatic logic [31:0] peek_refill(output int unsigned nb);
        logic [31:0] w;
        int unsigned avail;
        avail = shadow_wr - shadow_rd;
        nb    = (avail < REFILL_BYTES) ? avail : REFILL_BYTES;
        w     = '0;
        for (int i = 0; i < nb; i++)
        begin
            w |= 32'(shadow_store[shadow_rd + i]) << (24 - 8 * i);
        end
        return w;
    endfunction

    // Empty the window and consume whatever the refill fetched.
    function automatic void drop_window(int unsigned fetched);
        shadow_window = '0;
        shadow_valid  = 0;
        shadow_rd    += fetched;
    endfunction

    function automatic status_t take_bits(int unsigned n, output logic [31:0] val);
        logic [31:0] word;
        logic [63:0] wide;
        int unsigned nb;
        int unsigned rem;
        val = '0;
        if (shadow_valid >= n)
        begin
            wide          = {32'h0, shadow_window} >> (WINDOW_BITS - n);
            val           = wide[31:0];
            wide          = {32'h0, shadow_window} << n;
            shadow_window = wide[31:0];
            shadow_valid -= n;
            return ST_OK;
        end
        word = peek_refill(nb);
        if (shadow_valid + 8 * nb < n)
        begin
            drop_window(nb);
            return ST_END;
        end
        // Remaining window bits lead, refill bytes follow.
        rem           = n - shadow_valid;
        wide          = ({32'h0, shadow_window} >> (WINDOW_BITS - n))
                      | ({32'h0, word} >> (WINDOW_BITS - rem));
        val           = wide[31:0];
        wide          = {32'h0, word} << rem;
        shadow_window = wide[31:0];
        shadow_valid  = 8 * nb - rem;
        shadow_rd    += nb;
        return ST_OK;
    endfunction

    function automatic status_t read_code_num(output logic [31:0] code);
        int unsigned lz;
        int unsigned nb;
        int unsigned seen;
        logic [31:0] word;
        logic [31:0] raw;
        status_t     st;
        nb   = 0;
        code = '0;
        if (shadow_window != 0)
        begin
            lz = leading_zeros(shadow_window);
        end
        else
        begin
            word = peek_refill(nb);
            if (word == 0)
            begin
                // No one bit visible at all: too long if 16+ zeros were seen.
                seen = shadow_valid + 8 * nb;
                drop_window(nb);
                return (seen > MAX_LEAD_ZEROS) ? ST_LONG : ST_END;
            end
            lz = shadow_valid + leading_zeros(word);
        end
        if (lz > MAX_LEAD_ZEROS)
        begin
            drop_window(nb);
            return ST_LONG;
        end
        st = take_bits(2 * lz + 1, raw);
        if (st != ST_OK)
        begin
            return st;
        end
        code = raw - 1;
        return ST_OK;
    endfunction

    // Advance the shadow by one request and return the result it must give.
    function automatic reply_t decode_request(request_t rq);
        reply_t      rp;
        logic [31:0] k;
        int unsigned n;
        rp = '{uval: '0, sval: '0, st: ST_OK};
        k  = '0;
        case (rq.op)
            OP_LOAD:
            begin
                if (shadow_wr < STORE_BYTES)
                begin
                    shadow_store[shadow_wr] = rq.byt;
                    shadow_wr++;
                end
                else
                begin
                    rp.st = ST_FULL;
                end
            end
            OP_READ_BITS:
            begin
                n = (rq.cnt > WINDOW_BITS) ? WINDOW_BITS : rq.cnt;
                if (n != 0)
                begin
                    rp.st = take_bits(n, rp.uval);
                end
            end
            OP_READ_BIT:
            begin
                rp.st = take_bits(1, rp.uval);
            end
            OP_UE:
            begin
                rp.st = read_code_num(rp.uval);
            end
            OP_SE:
            begin
                rp.st = read_code_num(k);
                if (rp.st == ST_OK)
                begin
                    rp.uval = k;
                    rp.sval = k[0] ? ((k + 32'd1) >> 1) : (32'd0 - (k >> 1));
                end
            end
            OP_NEW_STREAM:
            begin
                shadow_window = '0;
                shadow_valid  = 0;
                shadow_rd     = 0;
                shadow_wr     = 0;
            end
            default:
            begin
            end
        endcase
        if (rp.st == ST_END || rp.st == ST_LONG)
        begin
            rp.uval = ERR_VALUE;
            rp.sval = '0;
        end
        return rp;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    function automatic void push_req(logic [2:0] op, logic [7:0] byt, logic [5:0] cnt);
        pending_reqs.push_back('{op: op, byt: byt, cnt: cnt});
        if (op == OP_LOAD && gen_wr < STORE_BYTES)
        begin
            gen_wr++;
        end
        else if (op == OP_NEW_STREAM)
        begin
            gen_wr = 0;
        end
    endfunction

    function automatic void emit_bits(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
        begin
            code_bits.push_back(v[i]);
        end
    endfunction

    function automatic void emit_zeros(int n);
        repeat (n) code_bits.push_back(1'b0);
    endfunction

    // Pad the bitstream to a byte boundary and turn it into load requests.
    function automatic void flush_loads();
        logic [7:0] b;
        while (code_bits.size() % 8 != 0)
        begin
            code_bits.push_back(1'($urandom_range(0, 1)));
        end
        while (code_bits.size() != 0)
        begin
            b = '0;
            repeat (8) b = {b[6:0], code_bits.pop_front()};
            push_req(OP_LOAD, b, 6'($urandom));
        end
    endfunction

    function automatic logic [2:0] any_read_op();
        case ($urandom_range(0, 3))
            0:       return OP_READ_BITS;
            1:       return OP_READ_BIT;
            2:       return OP_UE;
            default: return OP_SE;
        endcase
    endfunction

    // Mostly short codes, some long ones, now and then the longest legal one.
    function automatic int pick_lead_zeros();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
        begin
            return $urandom_range(0, 3);
        end
        if (r < 18)
        begin
            return $urandom_range(4, 14);
        end
        return MAX_LEAD_ZEROS;
    endfunction

    // Encode a run of requests, load the bytes, then issue the reads.
    function automatic void wellformed_episode();
        request_t   reads [$];
        int         n_req;
        int         sel;
        int         lz;
        int         c;
        logic [5:0] cnt;
        if ($urandom_range(0, 1) == 1 || gen_wr > STORE_BYTES - 64)
        begin
            push_req(OP_NEW_STREAM, 8'($urandom), 6'($urandom));
        end
        n_req = $urandom_range(1, 12);
        for (int i = 0; i < n_req; i++)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 12)
            begin
                lz = pick_lead_zeros();
                emit_zeros(lz);
                emit_bits(32'd1, 1);
                emit_bits($urandom, lz);
                reads.push_back('{op: (sel < 6) ? OP_UE : OP_SE,
                                  byt: 8'($urandom), cnt: 6'($urandom)});
            end
            else if (sel < 17)
            begin
                c = $urandom_range(1, 32);
                emit_bits($urandom, c);
                cnt = 6'(c);
                // Oversized counts clip to a full word.
                if (c == 32 && $urandom_range(0, 1) == 1)
                begin
                    cnt = 6'($urandom_range(33, 63));
                end
                reads.push_back('{op: OP_READ_BITS, byt: 8'($urandom), cnt: cnt});
            end
            else
            begin
                emit_bits($urandom, 1);
                reads.push_back('{op: OP_READ_BIT, byt: 8'($urandom), cnt: 6'($urandom)});
            end
        end
        flush_loads();
        foreach (reads[i])
        begin
            push_req(reads[i].op, reads[i].byt, reads[i].cnt);
        end
    endfunction

    // Broken sequences: overlong codes, truncated codes, reads past the data.
    function automatic void broken_episode();
        int n;
        case ($urandom_range(0, 3))
            0:
            begin
                push_req(OP_NEW_STREAM, 8'($urandom), 6'($urandom));
                emit_zeros($urandom_range(16, 40));
                emit_bits(32'd1, 1);
                emit_bits($urandom, $urandom_range(0, 16));
                flush_loads();
                push_req($urandom_range(0, 1) ? OP_UE : OP_SE, 8'($urandom), 6'($urandom));
            end
            1:
            begin
                repeat ($urandom_range(1, 4))
                begin
                    push_req(any_read_op(), 8'($urandom), 6'($urandom));
                end
            end
            2:
            begin
                push_req(OP_NEW_STREAM, 8'($urandom), 6'($urandom));
                n = $urandom_range(1, 4);
                repeat (n) push_req(OP_LOAD, 8'h00, 6'($urandom));
                push_req($urandom_range(0, 1) ? OP_UE : OP_SE, 8'($urandom), 6'($urandom));
            end
            default:
            begin
                push_req(OP_NEW_STREAM, 8'($urandom), 6'($urandom));
                emit_zeros($urandom_range(4, 15));
                emit_bits(32'd1, 1);
                flush_loads();
                push_req(OP_UE, 8'($urandom), 6'($urandom));
                push_req(OP_READ_BITS, 8'($urandom), 6'($urandom_range(1, 63)));
            end
        endcase
    endfunction

    function automatic void noise_episode();
        repeat ($urandom_range(1, 10))
        begin
            push_req(3'($urandom), 8'($urandom), 6'($urandom));
        end
    endfunction

    // Bytes heavy in zeros and small values, so lead-zero runs vary a lot.
    function automatic void sparse_episode();
        int r;
        if (gen_wr > STORE_BYTES - 64)
        begin
            push_req(OP_NEW_STREAM, 8'($urandom), 6'($urandom));
        end
        repeat ($urandom_range(2, 8))
        begin
            r = $urandom_range(0, 2);
            push_req(OP_LOAD, (r == 0) ? 8'h00 : (r == 1) ? 8'($urandom_range(1, 15))
                                                          : 8'($urandom), 6'($urandom));
        end
        repeat ($urandom_range(2, 6))
        begin
            push_req($urandom_range(0, 1) ? OP_UE : OP_SE, 8'($urandom), 6'($urandom));
        end
    endfunction

    // Load past the end of the store with reads sprinkled in between.
    function automatic void fill_store_episode();
        int n_loads;
        n_loads = STORE_BYTES - gen_wr + 3;
        for (int i = 0; i < n_loads; i++)
        begin
            push_req(OP_LOAD, 8'($urandom), 6'($urandom));
            if ($urandom_range(0, 3) == 0)
            begin
                push_req(any_read_op(), 8'($urandom), 6'($urandom));
            end
        end
        fill_done = 1'b1;
    endfunction

    function automatic void directed_requests();
        // Reads on an empty stream run out of data.
        push_req(OP_READ_BIT,  8'h00, 6'h00);
        push_req(OP_UE,        8'h00, 6'h00);
        // Undecoded opcodes, all payload bits set and then clear.
        push_req(OP_NOP6,      8'hFF, 6'h3F);
        push_req(OP_NOP7,      8'h00, 6'h00);
        // 1011_1000 then zeros and a late one: ue 0, se -1, se 0, overlong code.
        push_req(OP_LOAD,      8'hB8, 6'h00);
        push_req(OP_LOAD,      8'h00, 6'h00);
        push_req(OP_LOAD,      8'h01, 6'h00);
        push_req(OP_LOAD,      8'h00, 6'h00);
        push_req(OP_LOAD,      8'h00, 6'h00);
        push_req(OP_LOAD,      8'h00, 6'h00);
        push_req(OP_READ_BITS, 8'h00, 6'd0);
        push_req(OP_UE,        8'h00, 6'h00);
        push_req(OP_SE,        8'h00, 6'h00);
        push_req(OP_SE,        8'h00, 6'h00);
        push_req(OP_UE,        8'h00, 6'h00);
        // Empty window and only zero bytes left: too long with no one bit.
        push_req(OP_UE,        8'h00, 6'h00);
        // Fifteen leading zeros: the longest code that still decodes.
        push_req(OP_LOAD,      8'h00, 6'h00);
        push_req(OP_LOAD,      8'h01, 6'h00);
        push_req(OP_LOAD,      8'hFF, 6'h00);
        push_req(OP_LOAD,      8'hFE, 6'h00);
        push_req(OP_UE,        8'h00, 6'h00);
        // Oversized count clips to 32 and runs past the data.
        push_req(OP_READ_BITS, 8'h00, 6'd63);
        push_req(OP_NEW_STREAM, 8'h00, 6'h00);
        push_req(OP_LOAD,      8'h40, 6'h00);
        push_req(OP_SE,        8'h00, 6'h00);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer one request per transaction, with random gaps in between.
    // ------------------------------------------------------------------------
    int unsigned tx_wait = 0;
    bit          tx_pace = 1'b1;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            opcode    <= OP_LOAD;
            data_byte <= '0;
            bit_count <= '0;
            tx_wait    = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                replies_due.push_back(decode_request(live_req));
                op_hits[live_req.op]++;
                requests_sent++;
                // Switch between gapped and back-to-back stretches.
                if (requests_sent % 96 == 0)
                begin
                    tx_pace = ($urandom_range(0, 3) != 0);
                end
            end
            // Hold the payload while an offer is still waiting.
            if (!in_valid || in_ready)
            begin
                if (tx_wait != 0)
                begin
                    in_valid <= 1'b0;
                    tx_wait--;
                end
                else if (pending_reqs.size() != 0)
                begin
                    live_req   = pending_reqs.pop_front();
                    opcode    <= live_req.op;
                    data_byte <= live_req.byt;
                    bit_count <= live_req.cnt;
                    in_valid  <= 1'b1;
                    tx_wait    = tx_pace ? $urandom_range(0, 19) : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result transaction against the oldest prediction.
    // ------------------------------------------------------------------------
    int unsigned rx_stall = 0;
    int unsigned rx_hold  = 0;
    bit          rx_pace  = 1'b1;

    task automatic check_result();
        reply_t due;
        status_hits[status]++;
        if (replies_due.size() == 0)
        begin
            $error("unexpected result: unsigned_value %h signed_value %0d status %0d",
                   unsigned_value, signed_value, status);
            fail_count++;
            return;
        end
        due = replies_due.pop_front();
        if (unsigned_value !== due.uval)
        begin
            $error("unsigned_value: expected %h, actual %h", due.uval, unsigned_value);
            fail_count++;
        end
        if (signed_value !== due.sval)
        begin
            $error("signed_value: expected %0d, actual %0d", $signed(due.sval), signed_value);
            fail_count++;
        end
        if (status !== due.st)
        begin
            $error("status: expected %0d, actual %0d", due.st, status);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall   = 0;
            rx_hold    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_result();
                results_seen++;
                rx_stall = rx_pace ? $urandom_range(0, 19) : 0;
                if (results_seen % 80 == 0)
                begin
                    rx_pace = ($urandom_range(0, 3) != 0);
                end
                // Now and then stop draining for a long stretch while the
                // driver keeps offering, so the pipeline backs up into in_ready.
                if (results_seen % 1500 == 700)
                begin
                    rx_hold = HOLD_CYCLES;
                end
            end
            if (rx_hold != 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else if (rx_stall != 0)
            begin
                out_ready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, replies_due.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence: build all stimulus, release reset, drain, report.
    // ------------------------------------------------------------------------
    initial
    begin
        directed_requests();
        while (pending_reqs.size() < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            if (!fill_done && pending_reqs.size() > 600)
            begin
                fill_store_episode();
            end
            else
            begin
                case ($urandom_range(0, 9))
                    7:       noise_episode();
                    8:       broken_episode();
                    9:       sparse_episode();
                    default: wellformed_episode();
                endcase
            end
        end
        total_reqs = pending_reqs.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request is in and every prediction is matched.
        while (!(requests_sent == total_reqs && replies_due.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests: %0d load, %0d read-bits, %0d read-bit, %0d ue, %0d se, %0d restart, %0d nop",
                 op_hits[OP_LOAD], op_hits[OP_READ_BITS], op_hits[OP_READ_BIT],
                 op_hits[OP_UE], op_hits[OP_SE], op_hits[OP_NEW_STREAM],
                 op_hits[OP_NOP6] + op_hits[OP_NOP7]);
        $display("results: %0d ok, %0d past end, %0d store full, %0d overlong, %0d mismatches",
                 status_hits[ST_OK], status_hits[ST_END], status_hits[ST_FULL],
                 status_hits[ST_LONG], fail_count);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/egbr_pkg.sv
rtl/core/egbr_ram.sv
rtl/core/exp_golomb_bit_reader.sv
rtl/core/egbr_checker.sv
verif/tb_exp_golomb_bit_reader.sv
